### hdl/ssnf_pkg.sv
// ----------------------------------------------------------------------------
// ssnf_pkg
// Shared types, constants and the glyph lookup for the seven-segment number
// formatter.
// ----------------------------------------------------------------------------
package ssnf_pkg;

   // magnitude width fed to the conversion chain and number of bcd digits
   localparam int BIN_W   = 30;
   localparam int DIGITS  = 9;
   localparam int BCD_W   = 4 * DIGITS;
   localparam int HEX_W   = 20;
   localparam int GLYPHS  = 5;

   // decimal mode range limits, units of 0.00001
   localparam logic signed [31:0] DEC_POS_MAX = 32'sd999990000;
   localparam logic signed [31:0] DEC_NEG_MIN = -32'sd99990000;
   localparam logic signed [31:0] POS_UDF_LIM = 32'sd10;
   localparam logic signed [31:0] NEG_UDF_LIM = -32'sd100;
   localparam logic [31:0]        ROUND_ADD   = 32'd5;

   // special display codes
   localparam logic [2:0] SPC_NONE    = 3'd0;
   localparam logic [2:0] SPC_POS_OVF = 3'd1;
   localparam logic [2:0] SPC_NEG_OVF = 3'd2;
   localparam logic [2:0] SPC_POS_UDF = 3'd3;
   localparam logic [2:0] SPC_NEG_UDF = 3'd4;

   // command codes
   localparam logic CMD_DEC = 1'b0;
   localparam logic CMD_HEX = 1'b1;

   // fixed glyphs
   localparam logic [7:0] GLYPH_MINUS = 8'h01;
   localparam logic [7:0] GLYPH_POINT = 8'h80;
   localparam logic [7:0] GLYPH_F     = 8'h47;
   localparam logic [7:0] GLYPH_ZERO  = 8'h7E;

   // data carried by every pipeline stage
   typedef struct packed {
      logic             cmd;
      logic             neg;
      logic [2:0]       special;
      logic [HEX_W-1:0] hex;
      logic [BIN_W-1:0] bin;
      logic [BCD_W-1:0] bcd;
   } stage_type;

   // segment pattern of one hex nibble, a = bit 6 .. g = bit 0
   function automatic logic [7:0] seg_glyph(input logic [3:0] nib);
      logic [7:0] g;
      unique case (nib)
         4'h0: g = 8'h7E;
         4'h1: g = 8'h30;
         4'h2: g = 8'h6D;
         4'h3: g = 8'h79;
         4'h4: g = 8'h33;
         4'h5: g = 8'h5B;
         4'h6: g = 8'h5F;
         4'h7: g = 8'h70;
         4'h8: g = 8'h7F;
         4'h9: g = 8'h7B;
         4'hA: g = 8'h77;
         4'hB: g = 8'h1F;
         4'hC: g = 8'h4E;
         4'hD: g = 8'h3D;
         4'hE: g = 8'h4F;
         4'hF: g = 8'h47;
         default: g = 8'h00;
      endcase
      return g;
   endfunction

endpackage

### hdl/ssnf_front.sv
// ----------------------------------------------------------------------------
// ssnf_front
// Input stage: classifies the value, takes the rounded magnitude and registers
// the first stage word.
// ----------------------------------------------------------------------------
module ssnf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  logic                  up_command,
   input  logic signed [31:0]    up_value,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output ssnf_pkg::stage_type   dn_data
);

   logic                valid_ff;
   ssnf_pkg::stage_type data_ff;
   ssnf_pkg::stage_type data_in;
   logic [31:0]         mag;
   logic [31:0]         rnd;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   // magnitude plus half a display unit, and range classification
   always_comb begin
      mag = up_value[31] ? 32'(-up_value) : 32'(up_value);
      rnd = mag + ssnf_pkg::ROUND_ADD;

      data_in.cmd = up_command;
      data_in.neg = up_value[31];
      data_in.hex = up_value[ssnf_pkg::HEX_W-1:0];
      data_in.bin = rnd[ssnf_pkg::BIN_W-1:0];
      data_in.bcd = '0;

      priority if (up_value > ssnf_pkg::DEC_POS_MAX) begin
         data_in.special = ssnf_pkg::SPC_POS_OVF;
      end else if (up_value < ssnf_pkg::DEC_NEG_MIN) begin
         data_in.special = ssnf_pkg::SPC_NEG_OVF;
      end else if (up_value > 32'sd0 && up_value < ssnf_pkg::POS_UDF_LIM) begin
         data_in.special = ssnf_pkg::SPC_POS_UDF;
      end else if (up_value < 32'sd0 && up_value > ssnf_pkg::NEG_UDF_LIM) begin
         data_in.special = ssnf_pkg::SPC_NEG_UDF;
      end else begin
         data_in.special = ssnf_pkg::SPC_NONE;
      end
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### hdl/ssnf_cell.sv
// ----------------------------------------------------------------------------
// ssnf_cell
// One conversion cell: a single shift-and-add-3 step of binary to bcd
// conversion, registered, with its own valid and ready.
// ----------------------------------------------------------------------------
module ssnf_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  ssnf_pkg::stage_type   up_data,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output ssnf_pkg::stage_type   dn_data
);

   logic                          valid_ff;
   ssnf_pkg::stage_type           data_ff;
   ssnf_pkg::stage_type           data_in;
   logic [ssnf_pkg::BCD_W-1:0]    adj;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   // add 3 to every digit of 5 or more, then shift in the next binary bit
   always_comb begin
      adj = up_data.bcd;
      for (int i = 0; i < ssnf_pkg::DIGITS; i++) begin
         if (adj[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
         end
      end
      data_in     = up_data;
      data_in.bcd = {adj[ssnf_pkg::BCD_W-2:0], up_data.bin[ssnf_pkg::BIN_W-1]};
      data_in.bin = {up_data.bin[ssnf_pkg::BIN_W-2:0], 1'b0};
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### hdl/ssnf_back.sv
// ----------------------------------------------------------------------------
// ssnf_back
// Output stage: lays the bcd digits, sign and point out as five glyphs, or
// picks the hex or fixed patterns, into the result register.
// ----------------------------------------------------------------------------
module ssnf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  ssnf_pkg::stage_type   up_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_digit0,
   output logic [7:0]            rsp_digit1,
   output logic [7:0]            rsp_digit2,
   output logic [7:0]            rsp_digit3,
   output logic [7:0]            rsp_digit4
);

   logic       valid_ff;
   logic [7:0] glyph_ff [ssnf_pkg::GLYPHS];
   logic [7:0] glyph_in [ssnf_pkg::GLYPHS];
   logic [7:0] seq      [9];
   logic [3:0] dig      [ssnf_pkg::DIGITS];
   logic [1:0] lead;
   logic [3:0] idx;

   assign up_ready   = !valid_ff || rsp_ready;
   assign rsp_valid  = valid_ff;
   assign rsp_digit0 = glyph_ff[0];
   assign rsp_digit1 = glyph_ff[1];
   assign rsp_digit2 = glyph_ff[2];
   assign rsp_digit3 = glyph_ff[3];
   assign rsp_digit4 = glyph_ff[4];

   always_comb begin
      for (int k = 0; k < ssnf_pkg::DIGITS; k++) begin
         dig[k] = up_data.bcd[4*k +: 4];
      end

      // leading zeros of the integer part, the units digit always shows
      priority if (dig[8] != 4'd0) begin
         lead = 2'd0;
      end else if (dig[7] != 4'd0) begin
         lead = 2'd1;
      end else if (dig[6] != 4'd0) begin
         lead = 2'd2;
      end else begin
         lead = 2'd3;
      end

      // full text: minus, integer digits with point on the last, 4 fraction digits
      seq[0] = ssnf_pkg::GLYPH_MINUS;
      seq[1] = ssnf_pkg::seg_glyph(dig[8]);
      seq[2] = ssnf_pkg::seg_glyph(dig[7]);
      seq[3] = ssnf_pkg::seg_glyph(dig[6]);
      seq[4] = ssnf_pkg::seg_glyph(dig[5]) | ssnf_pkg::GLYPH_POINT;
      seq[5] = ssnf_pkg::seg_glyph(dig[4]);
      seq[6] = ssnf_pkg::seg_glyph(dig[3]);
      seq[7] = ssnf_pkg::seg_glyph(dig[2]);
      seq[8] = ssnf_pkg::seg_glyph(dig[1]);

      idx = 4'd0;
      for (int p = 0; p < ssnf_pkg::GLYPHS; p++) begin
         glyph_in[p] = '0;
      end

      if (up_data.cmd == ssnf_pkg::CMD_HEX) begin
         // hex glyphs, most significant nibble first
         for (int p = 0; p < ssnf_pkg::GLYPHS; p++) begin
            glyph_in[p] = ssnf_pkg::seg_glyph(up_data.hex[4*(ssnf_pkg::GLYPHS-1-p) +: 4]);
         end
      end else begin
         unique case (up_data.special)
            ssnf_pkg::SPC_POS_OVF: begin
               for (int p = 0; p < ssnf_pkg::GLYPHS; p++) begin
                  glyph_in[p] = ssnf_pkg::GLYPH_F;
               end
               glyph_in[4] = ssnf_pkg::GLYPH_F | ssnf_pkg::GLYPH_POINT;
            end
            ssnf_pkg::SPC_NEG_OVF: begin
               for (int p = 1; p < ssnf_pkg::GLYPHS; p++) begin
                  glyph_in[p] = ssnf_pkg::GLYPH_F;
               end
               glyph_in[0] = ssnf_pkg::GLYPH_MINUS;
               glyph_in[4] = ssnf_pkg::GLYPH_F | ssnf_pkg::GLYPH_POINT;
            end
            ssnf_pkg::SPC_POS_UDF: begin
               for (int p = 1; p < ssnf_pkg::GLYPHS; p++) begin
                  glyph_in[p] = ssnf_pkg::GLYPH_ZERO;
               end
               glyph_in[0] = ssnf_pkg::GLYPH_ZERO | ssnf_pkg::GLYPH_POINT;
            end
            ssnf_pkg::SPC_NEG_UDF: begin
               for (int p = 2; p < ssnf_pkg::GLYPHS; p++) begin
                  glyph_in[p] = ssnf_pkg::GLYPH_ZERO;
               end
               glyph_in[0] = ssnf_pkg::GLYPH_MINUS;
               glyph_in[1] = ssnf_pkg::GLYPH_ZERO | ssnf_pkg::GLYPH_POINT;
            end
            default: begin
               // window of five glyphs starting at the first shown character
               for (int p = 0; p < ssnf_pkg::GLYPHS; p++) begin
                  idx = 4'd1 + 4'(lead) + 4'(p) - 4'(up_data.neg);
                  glyph_in[p] = seq[idx];
               end
               if (up_data.neg) begin
                  glyph_in[0] = ssnf_pkg::GLYPH_MINUS;
               end
            end
         endcase
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   // result glyphs
   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         glyph_ff <= glyph_in;
      end
   end

endmodule

### hdl/seven_segment_number_formatter.sv
// ----------------------------------------------------------------------------
// seven_segment_number_formatter
// Formats one signed fixed-point or hex number as five seven-segment glyphs.
// ----------------------------------------------------------------------------
// The block takes one number per clock while the result side does not stall
// and returns its five glyphs through one input register, a row of 30
// conversion cells that each turn one bit of the rounded magnitude into bcd,
// and one output register that lays out the glyphs. Every stage has its own
// valid bit and passes items on as soon as the next stage is free, so a
// stalled result only blocks the input once the whole row is full.
module seven_segment_number_formatter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_command,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_digit0,
   output logic [7:0]         rsp_digit1,
   output logic [7:0]         rsp_digit2,
   output logic [7:0]         rsp_digit3,
   output logic [7:0]         rsp_digit4
);

   localparam int CELLS = ssnf_pkg::BIN_W;

   logic                chain_valid [CELLS+1];
   logic                chain_ready [CELLS+1];
   ssnf_pkg::stage_type chain_data  [CELLS+1];

   // input stage
   ssnf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_valid),
      .up_ready   (req_ready),
      .up_command (req_command),
      .up_value   (req_value),
      .dn_valid   (chain_valid[0]),
      .dn_ready   (chain_ready[0]),
      .dn_data    (chain_data[0])
   );

   // conversion chain, one cell per magnitude bit
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      ssnf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[i]),
         .up_ready (chain_ready[i]),
         .up_data  (chain_data[i]),
         .dn_valid (chain_valid[i+1]),
         .dn_ready (chain_ready[i+1]),
         .dn_data  (chain_data[i+1])
      );
   end

   // glyph layout and result register
   ssnf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (chain_valid[CELLS]),
      .up_ready   (chain_ready[CELLS]),
      .up_data    (chain_data[CELLS]),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_digit0 (rsp_digit0),
      .rsp_digit1 (rsp_digit1),
      .rsp_digit2 (rsp_digit2),
      .rsp_digit3 (rsp_digit3),
      .rsp_digit4 (rsp_digit4)
   );

   // input only stalls when the whole row is full behind a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled while the result side can move");

   // at most one decimal point among the glyphs
   a_one_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_digit0[7], rsp_digit1[7], rsp_digit2[7],
                              rsp_digit3[7], rsp_digit4[7]}))
      else $error("more than one decimal point shown");

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule
